// ===== src/ultrasonic_sweep_scanner_assert.svh =====
// assertion macros used by the scanner top level
`ifndef ULTRASONIC_SWEEP_SCANNER_ASSERT_SVH
`define ULTRASONIC_SWEEP_SCANNER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define USS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define USS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/uss_pkg.sv =====
// types, constants and register map of the ultrasonic sweep scanner
package uss_pkg;

	localparam int CNT_W = 16;
	localparam int ANGLE_W = 8;
	localparam int STEP_W = 7;
	localparam int FRAME_W = 8;
	localparam int BASE_W = 12;
	localparam int GAIN_W = 4;
	localparam int DIST_W = 10;
	localparam int SERVO_W = 13;

	localparam int DIST_DIVISOR_DEF = 4;
	localparam int DIST_DIV_MAX = 16;

	localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 8'd180;
	localparam logic [SERVO_W-1:0] SERVO_RESET = 13'd1500;

	// register reset values
	localparam logic [FRAME_W-1:0] TICKS_RESET = 8'd25;
	localparam logic [STEP_W-1:0] ASTEP_RESET = 7'd10;
	localparam logic [ANGLE_W-1:0] AMAX_RESET = 8'd180;
	localparam logic [BASE_W-1:0] BASE_RESET = 12'd600;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd10;
	localparam logic [DIST_W-1:0] LIMIT_RESET = 10'd50;
	localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd30000;
	localparam logic [CNT_W-1:0] SETTLE_RESET = 16'd5000;

	// register map
	localparam int ADDR_W = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_TICKS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ASTEP = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_AMAX = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BASE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GAIN = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SETTLE = 3'd7;

	typedef struct packed {
		logic [FRAME_W-1:0] ticks_per_step;
		logic [STEP_W-1:0] angle_step;
		logic [ANGLE_W-1:0] angle_max;
		logic [BASE_W-1:0] servo_base;
		logic [GAIN_W-1:0] servo_gain;
		logic [DIST_W-1:0] alert_limit;
		logic [CNT_W-1:0] echo_timeout;
		logic [CNT_W-1:0] settle_samples;
	} cfg_t;

	typedef struct packed {
		logic frame_tick;
		logic echo;
	} sample_t;

	typedef struct packed {
		logic [SERVO_W-1:0] servo_compare;
		logic trigger;
		logic alert;
		logic [ANGLE_W-1:0] alert_angle;
		logic [DIST_W-1:0] alert_distance;
		logic busy_res;
	} result_t;

	// sequencer view of one sample, handed to the range unit
	typedef struct packed {
		logic [SERVO_W-1:0] servo_compare;
		logic trigger;
		logic busy;
		logic measured;
		logic [CNT_W-1:0] width;
		logic [ANGLE_W-1:0] angle;
	} step_t;

	typedef struct packed {
		logic alert;
		logic [ANGLE_W-1:0] angle;
		logic [DIST_W-1:0] distance;
	} alert_t;

endpackage

// ===== src/uss_cfg.sv =====
// apb register file holding the scanner configuration
module uss_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [uss_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output uss_pkg::cfg_t cfg
);

	uss_pkg::cfg_t cfg_q;
	logic wr_en;
	logic [uss_pkg::REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign idx = paddr[uss_pkg::ADDR_W-1:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_step <= uss_pkg::TICKS_RESET;
			cfg_q.angle_step <= uss_pkg::ASTEP_RESET;
			cfg_q.angle_max <= uss_pkg::AMAX_RESET;
			cfg_q.servo_base <= uss_pkg::BASE_RESET;
			cfg_q.servo_gain <= uss_pkg::GAIN_RESET;
			cfg_q.alert_limit <= uss_pkg::LIMIT_RESET;
			cfg_q.echo_timeout <= uss_pkg::TIMEOUT_RESET;
			cfg_q.settle_samples <= uss_pkg::SETTLE_RESET;
		end else if (wr_en) begin
			unique case (idx)
				uss_pkg::REG_TICKS: cfg_q.ticks_per_step <= pwdata[uss_pkg::FRAME_W-1:0];
				uss_pkg::REG_ASTEP: cfg_q.angle_step <= pwdata[uss_pkg::STEP_W-1:0];
				uss_pkg::REG_AMAX: cfg_q.angle_max <= pwdata[uss_pkg::ANGLE_W-1:0];
				uss_pkg::REG_BASE: cfg_q.servo_base <= pwdata[uss_pkg::BASE_W-1:0];
				uss_pkg::REG_GAIN: cfg_q.servo_gain <= pwdata[uss_pkg::GAIN_W-1:0];
				uss_pkg::REG_LIMIT: cfg_q.alert_limit <= pwdata[uss_pkg::DIST_W-1:0];
				uss_pkg::REG_TIMEOUT: cfg_q.echo_timeout <= pwdata[uss_pkg::CNT_W-1:0];
				uss_pkg::REG_SETTLE: cfg_q.settle_samples <= pwdata[uss_pkg::CNT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			uss_pkg::REG_TICKS: prdata = 32'(cfg_q.ticks_per_step);
			uss_pkg::REG_ASTEP: prdata = 32'(cfg_q.angle_step);
			uss_pkg::REG_AMAX: prdata = 32'(cfg_q.angle_max);
			uss_pkg::REG_BASE: prdata = 32'(cfg_q.servo_base);
			uss_pkg::REG_GAIN: prdata = 32'(cfg_q.servo_gain);
			uss_pkg::REG_LIMIT: prdata = 32'(cfg_q.alert_limit);
			uss_pkg::REG_TIMEOUT: prdata = 32'(cfg_q.echo_timeout);
			uss_pkg::REG_SETTLE: prdata = 32'(cfg_q.settle_samples);
			default: prdata = '0;
		endcase
	end

endmodule

// ===== src/uss_ctrl.sv =====
// scan step sequencer: frame counting, settle, trigger, echo timing, sweep angle
module uss_ctrl (
	input logic clk,
	input logic arst_n,
	input logic en,
	input uss_pkg::sample_t sample,
	input uss_pkg::cfg_t cfg,
	output uss_pkg::step_t step
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SETTLE = 2'd1;
	localparam logic [1:0] PH_WAIT = 2'd2;
	localparam logic [1:0] PH_MEASURE = 2'd3;

	logic [uss_pkg::FRAME_W-1:0] frame_count_q, frame_count_n;
	logic step_pending_q, step_pending_n;
	logic [1:0] phase_q, phase_n;
	logic [uss_pkg::CNT_W-1:0] phase_count_q, phase_count_n;
	logic [uss_pkg::CNT_W-1:0] width_count_q, width_count_n;
	logic [uss_pkg::ANGLE_W-1:0] sweep_angle_q, sweep_angle_n;
	logic sweep_down_q, sweep_down_n;
	logic [uss_pkg::SERVO_W-1:0] servo_value_q, servo_value_n;

	logic [uss_pkg::FRAME_W:0] frame_inc;
	logic [uss_pkg::CNT_W-1:0] pc_inc;
	logic [uss_pkg::ANGLE_W-1:0] ang_clip;
	logic [uss_pkg::BASE_W-1:0] gain_prod;
	logic signed [uss_pkg::ANGLE_W+1:0] ang_next;
	logic trig, busy, finish, measured;

	assign frame_inc = {1'b0, frame_count_q} + 1'b1;
	assign pc_inc = phase_count_q + 1'b1;
	assign ang_clip = (sweep_angle_q > uss_pkg::ANGLE_LIMIT) ? uss_pkg::ANGLE_LIMIT
		: sweep_angle_q;
	assign gain_prod = uss_pkg::BASE_W'(cfg.servo_gain * ang_clip);
	// signed angle move, bounced at zero and at angle_max
	assign ang_next = sweep_down_q
		? $signed({2'b00, sweep_angle_q}) - $signed({3'b000, cfg.angle_step})
		: $signed({2'b00, sweep_angle_q}) + $signed({3'b000, cfg.angle_step});

	always_comb begin
		frame_count_n = frame_count_q;
		step_pending_n = step_pending_q;
		phase_n = phase_q;
		phase_count_n = phase_count_q;
		width_count_n = width_count_q;
		sweep_angle_n = sweep_angle_q;
		sweep_down_n = sweep_down_q;
		servo_value_n = servo_value_q;
		trig = 1'b0;
		busy = 1'b0;
		finish = 1'b0;
		measured = 1'b0;

		if (sample.frame_tick) begin
			if (frame_inc >= {1'b0, cfg.ticks_per_step}) begin
				frame_count_n = '0;
				step_pending_n = 1'b1;
			end else begin
				frame_count_n = frame_inc[uss_pkg::FRAME_W-1:0];
			end
		end

		unique case (phase_q)
			PH_IDLE: begin
				if (step_pending_n) begin
					step_pending_n = 1'b0;
					servo_value_n = {1'b0, cfg.servo_base} + {1'b0, gain_prod};
					phase_n = PH_SETTLE;
					phase_count_n = '0;
					busy = 1'b1;
				end
			end
			PH_SETTLE: begin
				busy = 1'b1;
				if (phase_count_q >= cfg.settle_samples) begin
					trig = 1'b1;
					phase_n = PH_WAIT;
					phase_count_n = '0;
				end else begin
					phase_count_n = pc_inc;
				end
			end
			PH_WAIT: begin
				busy = 1'b1;
				if (sample.echo) begin
					width_count_n = 16'd1;
					phase_n = PH_MEASURE;
				end else begin
					phase_count_n = pc_inc;
					if (pc_inc >= cfg.echo_timeout) begin
						// timeout: no echo seen, distance reads as zero
						width_count_n = '0;
						finish = 1'b1;
					end
				end
			end
			PH_MEASURE: begin
				busy = 1'b1;
				if (sample.echo && (width_count_q < cfg.echo_timeout)) begin
					width_count_n = width_count_q + 1'b1;
				end else begin
					finish = 1'b1;
					measured = 1'b1;
				end
			end
			default: phase_n = PH_IDLE;
		endcase

		if (finish) begin
			if (ang_next >= $signed({2'b00, cfg.angle_max})) begin
				sweep_angle_n = cfg.angle_max;
				sweep_down_n = 1'b1;
			end else if (ang_next <= $signed(10'sd0)) begin
				sweep_angle_n = '0;
				sweep_down_n = 1'b0;
			end else begin
				sweep_angle_n = ang_next[uss_pkg::ANGLE_W-1:0];
			end
			phase_n = PH_IDLE;
			phase_count_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			step_pending_q <= 1'b0;
			phase_q <= PH_IDLE;
			phase_count_q <= '0;
			width_count_q <= '0;
			sweep_angle_q <= '0;
			sweep_down_q <= 1'b0;
			servo_value_q <= uss_pkg::SERVO_RESET;
		end else if (en) begin
			frame_count_q <= frame_count_n;
			step_pending_q <= step_pending_n;
			phase_q <= phase_n;
			phase_count_q <= phase_count_n;
			width_count_q <= width_count_n;
			sweep_angle_q <= sweep_angle_n;
			sweep_down_q <= sweep_down_n;
			servo_value_q <= servo_value_n;
		end
	end

	assign step.servo_compare = servo_value_n;
	assign step.trigger = trig;
	assign step.busy = busy;
	assign step.measured = measured;
	assign step.width = width_count_q;
	assign step.angle = sweep_angle_q;

endmodule

// ===== src/uss_range.sv =====
// echo width to distance by reciprocal multiply, and the alert decision
module uss_range #(
	parameter int DIST_DIVISOR = uss_pkg::DIST_DIVISOR_DEF
) (
	input uss_pkg::step_t step,
	input logic [uss_pkg::DIST_W-1:0] alert_limit,
	output uss_pkg::alert_t res
);

	// exact floor division for all widths below 2**CNT_W and divisors up to DIST_DIV_MAX
	localparam int DIV_SHIFT = uss_pkg::CNT_W + $clog2(uss_pkg::DIST_DIV_MAX);
	localparam int MULT_W = DIV_SHIFT + 1;
	localparam int PROD_W = uss_pkg::CNT_W + MULT_W;
	localparam logic [MULT_W-1:0] DIV_MULT =
		MULT_W'(((2 ** DIV_SHIFT) + DIST_DIVISOR - 1) / DIST_DIVISOR);

	logic [PROD_W-1:0] prod;
	logic [uss_pkg::CNT_W-1:0] quot;
	logic hit;

	assign prod = PROD_W'(step.width) * PROD_W'(DIV_MULT);
	assign quot = prod[DIV_SHIFT +: uss_pkg::CNT_W];
	assign hit = step.measured && (quot != '0)
		&& (quot < uss_pkg::CNT_W'(alert_limit));

	assign res.alert = hit;
	assign res.angle = hit ? step.angle : '0;
	assign res.distance = hit ? quot[uss_pkg::DIST_W-1:0] : '0;

endmodule

// ===== src/ultrasonic_sweep_scanner.sv =====
// top level of the servo sweep ultrasonic range scanner
// a result is registered at the edge that accepts its sample
// throughput: one sample request per cycle, limited only by result_ready
// the output register lets a new sample in while the held result is taken
// reset (arst_n low): configuration to defaults, sweep at 0 degrees going up,
// servo compare 1500, no step pending, no result held
module ultrasonic_sweep_scanner #(
	parameter int DIST_DIVISOR = uss_pkg::DIST_DIVISOR_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input uss_pkg::sample_t sample,
	output logic result_valid,
	input logic result_ready,
	output uss_pkg::result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [uss_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	uss_pkg::cfg_t cfg;
	uss_pkg::step_t step;
	uss_pkg::alert_t alert_res;
	uss_pkg::result_t result_q;
	logic result_valid_q;
	logic accept;

	assign sample_ready = !result_valid_q || result_ready;
	assign accept = sample_valid && sample_ready;

	uss_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	uss_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.en(accept),
		.sample(sample),
		.cfg(cfg),
		.step(step)
	);

	uss_range #(
		.DIST_DIVISOR(DIST_DIVISOR)
	) u_range (
		.step(step),
		.alert_limit(cfg.alert_limit),
		.res(alert_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.servo_compare <= step.servo_compare;
			result_q.trigger <= step.trigger;
			result_q.alert <= alert_res.alert;
			result_q.alert_angle <= alert_res.angle;
			result_q.alert_distance <= alert_res.distance;
			result_q.busy_res <= step.busy;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`include "ultrasonic_sweep_scanner_assert.svh"

	`USS_ASSERT_NOW(a_stall_blocks, result_valid_q && !result_ready, !sample_ready, "sample taken while result stalled")
	`USS_ASSERT_NEXT(a_accept_fills, accept, result_valid_q, "accepted sample gave no result")
	`USS_ASSERT_NOW(a_alert_busy, result_valid_q && result_q.alert, result_q.busy_res && !result_q.trigger, "alert outside step end")
	`USS_ASSERT_NOW(a_alert_dist, result_valid_q && result_q.alert, result_q.alert_distance != '0 && result_q.alert_distance < cfg.alert_limit, "alert distance out of range")
	`USS_ASSERT_NOW(a_quiet_fields, result_valid_q && !result_q.alert, result_q.alert_angle == '0 && result_q.alert_distance == '0, "alert fields set without alert")

endmodule

// ===== sim/uss_checker.sv =====
// checker for the scanner: predicts the result of every sample request and compares
module uss_checker
	import uss_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_ready,
	input sample_t sample,
	input logic result_valid,
	input logic result_ready,
	input result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	output int errors,
	output int outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_SETTLE, SCAN_WAIT, SCAN_MEASURE} scan_phase_t;

	cfg_t cfg;
	logic [FRAME_W-1:0] frame_cnt;
	logic step_req;
	scan_phase_t phase;
	logic [CNT_W-1:0] phase_cnt;
	logic [CNT_W-1:0] width_cnt;
	logic [ANGLE_W-1:0] sweep_angle;
	logic sweep_down;
	logic [SERVO_W-1:0] servo_value;
	result_t pending_results[$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// advances the scan state by one sample and returns what the block shows for it
	function automatic result_t scan_predict(sample_t s);
		result_t r;
		int c;
		int ang;
		int a;
		int d;
		logic done;
		r = '0;
		done = 1'b0;
		if (s.frame_tick) begin
			c = int'(frame_cnt) + 1;
			if (c >= int'(cfg.ticks_per_step)) begin
				frame_cnt = '0;
				step_req = 1'b1;
			end else begin
				frame_cnt = c[FRAME_W-1:0];
			end
		end
		case (phase)
			SCAN_IDLE: begin
				if (step_req) begin
					ang = (sweep_angle > ANGLE_LIMIT) ? int'(ANGLE_LIMIT) : int'(sweep_angle);
					step_req = 1'b0;
					servo_value = SERVO_W'(int'(cfg.servo_base) + int'(cfg.servo_gain) * ang);
					phase = SCAN_SETTLE;
					phase_cnt = '0;
					r.busy_res = 1'b1;
				end
			end
			SCAN_SETTLE: begin
				r.busy_res = 1'b1;
				if (phase_cnt >= cfg.settle_samples) begin
					r.trigger = 1'b1;
					phase = SCAN_WAIT;
					phase_cnt = '0;
				end else begin
					phase_cnt = phase_cnt + 1'b1;
				end
			end
			SCAN_WAIT: begin
				r.busy_res = 1'b1;
				if (s.echo) begin
					width_cnt = CNT_W'(1);
					phase = SCAN_MEASURE;
				end else begin
					phase_cnt = phase_cnt + 1'b1;
					// no echo in time: step ends with zero distance
					if (phase_cnt >= cfg.echo_timeout) begin
						width_cnt = '0;
						done = 1'b1;
					end
				end
			end
			default: begin
				r.busy_res = 1'b1;
				if (s.echo && width_cnt < cfg.echo_timeout)
					width_cnt = width_cnt + 1'b1;
				else
					done = 1'b1;
			end
		endcase
		if (done) begin
			d = int'(width_cnt) / DIST_DIVISOR_DEF;
			if (d > 0 && d < int'(cfg.alert_limit)) begin
				r.alert = 1'b1;
				r.alert_angle = sweep_angle;
				r.alert_distance = d[DIST_W-1:0];
			end
			a = sweep_down ? int'(sweep_angle) - int'(cfg.angle_step)
				: int'(sweep_angle) + int'(cfg.angle_step);
			if (a >= int'(cfg.angle_max)) begin
				a = int'(cfg.angle_max);
				sweep_down = 1'b1;
			end else if (a <= 0) begin
				a = 0;
				sweep_down = 1'b0;
			end
			sweep_angle = a[ANGLE_W-1:0];
			phase = SCAN_IDLE;
			phase_cnt = '0;
		end
		r.servo_compare = servo_value;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cfg = '{ticks_per_step: TICKS_RESET, angle_step: ASTEP_RESET,
				angle_max: AMAX_RESET, servo_base: BASE_RESET, servo_gain: GAIN_RESET,
				alert_limit: LIMIT_RESET, echo_timeout: TIMEOUT_RESET,
				settle_samples: SETTLE_RESET};
			frame_cnt = '0;
			step_req = 1'b0;
			phase = SCAN_IDLE;
			phase_cnt = '0;
			width_cnt = '0;
			sweep_angle = '0;
			sweep_down = 1'b0;
			servo_value = SERVO_RESET;
			pending_results.delete();
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_TICKS: cfg.ticks_per_step = pwdata[FRAME_W-1:0];
					REG_ASTEP: cfg.angle_step = pwdata[STEP_W-1:0];
					REG_AMAX: cfg.angle_max = pwdata[ANGLE_W-1:0];
					REG_BASE: cfg.servo_base = pwdata[BASE_W-1:0];
					REG_GAIN: cfg.servo_gain = pwdata[GAIN_W-1:0];
					REG_LIMIT: cfg.alert_limit = pwdata[DIST_W-1:0];
					REG_TIMEOUT: cfg.echo_timeout = pwdata[CNT_W-1:0];
					REG_SETTLE: cfg.settle_samples = pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
			// results leave before this edge's request is predicted
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no request waiting");
				end else begin
					want = pending_results.pop_front();
					check_field("servo_compare", result.servo_compare, want.servo_compare);
					check_field("trigger", result.trigger, want.trigger);
					check_field("alert", result.alert, want.alert);
					check_field("alert_angle", result.alert_angle, want.alert_angle);
					check_field("alert_distance", result.alert_distance, want.alert_distance);
					check_field("busy_res", result.busy_res, want.busy_res);
				end
			end
			if (sample_valid && sample_ready)
				pending_results.push_back(scan_predict(sample));
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// testbench top: clock, reset, register setup and sample stimulus for the scanner
module tb_top
	import uss_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_500_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	sample_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int errors;
	int outstanding;

	int cycles = 0;
	bit idle_on = 1'b0;
	int stall_left = 0;
	cfg_t cur_cfg;
	logic echo_lvl = 1'b0;
	int run_left = 0;

	// an echo that runs into the width cap, then a timeout
	sample_t directed_seq [17] = '{2'b10, 2'b00, 2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b11,
		2'b01, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00};

	ultrasonic_sweep_scanner uut (.*);

	uss_checker u_checker (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = idle_len() - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic push_sample(input sample_t s);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_config(input cfg_t c);
		wait_drained();
		apb_write(REG_TICKS, 32'(c.ticks_per_step));
		apb_write(REG_ASTEP, 32'(c.angle_step));
		apb_write(REG_AMAX, 32'(c.angle_max));
		apb_write(REG_BASE, 32'(c.servo_base));
		apb_write(REG_GAIN, 32'(c.servo_gain));
		apb_write(REG_LIMIT, 32'(c.alert_limit));
		apb_write(REG_TIMEOUT, 32'(c.echo_timeout));
		apb_write(REG_SETTLE, 32'(c.settle_samples));
		cur_cfg = c;
	endtask

	// echo comes as runs of high and low around the timeout, with some glitches
	task automatic run_random(input int n, input int tick_pct);
		sample_t s;
		int t;
		t = int'(cur_cfg.echo_timeout);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				idle_on = $urandom_range(0, 3) != 0;
			if (run_left == 0) begin
				echo_lvl = ~echo_lvl;
				case ($urandom_range(0, 3))
					0: run_left = $urandom_range(1, 3);
					3: run_left = $urandom_range(t + 1, 2 * t + 8);
					default: run_left = $urandom_range(1, t + 4);
				endcase
			end
			run_left--;
			s.echo = echo_lvl ^ ($urandom_range(0, 15) == 0);
			s.frame_tick = $urandom_range(0, 99) < tick_pct;
			push_sample(s);
		end
	endtask

	initial begin
		cfg_t rc;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings, every sample value
		for (int v = 0; v < 4; v++)
			push_sample(sample_t'(2'(v)));

		load_config('{8'd1, 7'd90, 8'd180, 12'd4095, 4'd15, 10'd1023, 16'd6, 16'd0});
		foreach (directed_seq[i])
			push_sample(directed_seq[i]);

		load_config('{8'd1, 7'd10, 8'd180, 12'd600, 4'd10, 10'd50, 16'd40, 16'd2});
		run_random(125, 30);
		load_config('{8'd0, 7'd90, 8'd180, 12'd4095, 4'd15, 10'd1023, 16'd16, 16'd0});
		run_random(125, 20);
		load_config('{8'd3, 7'd1, 8'd1, 12'd0, 4'd0, 10'd1, 16'd1, 16'd1});
		run_random(125, 60);
		// sweep limit above 180 degrees, zero timeout
		load_config('{8'd2, 7'd127, 8'd255, 12'd4095, 4'd15, 10'd3, 16'd0, 16'd0});
		run_random(125, 50);
		load_config('{8'd255, 7'd0, 8'd180, 12'd100, 4'd3, 10'd1023, 16'd20, 16'd3});
		run_random(100, 100);
		repeat (3) begin
			rc.ticks_per_step = FRAME_W'($urandom_range(0, 4));
			rc.angle_step = STEP_W'($urandom_range(0, 127));
			rc.angle_max = ANGLE_W'($urandom_range(0, 255));
			rc.servo_base = BASE_W'($urandom_range(0, 4095));
			rc.servo_gain = GAIN_W'($urandom_range(0, 15));
			rc.alert_limit = DIST_W'($urandom_range(0, 1023));
			rc.echo_timeout = CNT_W'($urandom_range(0, 30));
			rc.settle_samples = CNT_W'($urandom_range(0, 8));
			load_config(rc);
			run_random(125, $urandom_range(10, 80));
		end

		wait_drained();
		repeat (2) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/uss_pkg.sv
src/uss_cfg.sv
src/uss_ctrl.sv
src/uss_range.sv
src/ultrasonic_sweep_scanner.sv
sim/uss_checker.sv
sim/tb_top.sv
